// ----- design/rnrs_pkg.sv -----
// shared types, constants and helpers for the random no-repeat selector
`default_nettype none

package rnrs_pkg;

   // request and response field widths
   localparam int SLOT_WIDTH   = 6;
   localparam int COUNT_WIDTH  = 8;
   localparam int CHOICE_WIDTH = 8;
   localparam int DRAWS_WIDTH  = 9;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int HIST_REG_WIDTH  = 5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HISTORY_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED           = 1'b1;

   localparam logic [HIST_REG_WIDTH-1:0] RESET_HISTORY_LENGTH = 5'd1;
   localparam logic [HIST_REG_WIDTH-1:0] HISTORY_CAP          = 5'd16;

   // generator
   localparam int GEN_WIDTH = 32;
   localparam logic [GEN_WIDTH-1:0] SEED_ZERO_SUBST = 32'h9e37_79b9;
   localparam logic [GEN_WIDTH-1:0] RESET_SEED      = 32'h9e37_79b9;
   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   // modulo unit: radix-16 restoring division
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = GEN_WIDTH / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_WIDTH      = $clog2(DIV_CYCLES);

   // defaults for the top level parameters
   localparam int DEFAULT_NUM_SLOTS   = 64;
   localparam int DEFAULT_MAX_HISTORY = 16;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_DIVIDE,
      ST_CHECK,
      ST_SCAN,
      ST_UPDATE,
      ST_WRAP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic take_req;
      logic draw;
      logic div_step;
      logic check;
      logic scan_step;
      logic scan_take;
      logic wrap_start;
      logic finish;
      logic use_scan;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic probe_recent;
      logic redraw_ok;
      logic scan_end;
      logic limit_zero;
      logic rsp_free;
   } status_type;

   function automatic logic [GEN_WIDTH-1:0] xorshift32(input logic [GEN_WIDTH-1:0] s);
      logic [GEN_WIDTH-1:0] t;
      t = s ^ (s << XS_SHIFT_A);
      t = t ^ (t >> XS_SHIFT_B);
      t = t ^ (t << XS_SHIFT_C);
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- design/rnrs_if.sv -----
// request and response channel interfaces
`default_nettype none

interface rnrs_req_if import rnrs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SLOT_WIDTH-1:0]  slot;
   logic [COUNT_WIDTH-1:0] choice_count;

   modport source (output valid, slot, choice_count, input ready);
   modport sink   (input valid, slot, choice_count, output ready);
endinterface

interface rnrs_rsp_if import rnrs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CHOICE_WIDTH-1:0] choice;
   logic [DRAWS_WIDTH-1:0]  draws_used;
   logic                    used_fallback;

   modport source (output valid, choice, draws_used, used_fallback, input ready);
   modport sink   (input valid, choice, draws_used, used_fallback, output ready);
endinterface

`default_nettype wire

// ----- design/rnrs_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module rnrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/rnrs_mod_unit.sv -----
// iterative 32 by 8 bit remainder unit, four quotient bits per cycle while step is high
`default_nettype none

module rnrs_mod_unit import rnrs_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    step,
   input  wire logic [GEN_WIDTH-1:0]    dividend,
   input  wire logic [COUNT_WIDTH-1:0]  divisor,
   output logic      [COUNT_WIDTH-1:0]  remainder,
   output logic                         last
);

   logic [GEN_WIDTH-1:0]     quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]   den_ff, den_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [GEN_WIDTH-1:0]     q_work;
   logic [COUNT_WIDTH-1:0]   r_work;
   logic [COUNT_WIDTH:0]     trial;

   // four dependent compare-subtract steps on 9 bit values
   always_comb begin
      q_work = quo_ff;
      r_work = rem_ff;
      trial  = '0;
      for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
         trial  = {r_work, q_work[GEN_WIDTH-1]};
         q_work = q_work << 1;
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
         end
         r_work = trial[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         quo_in = q_work;
         rem_in = r_work;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign remainder = rem_ff;
   assign last      = (cnt_ff == DIV_CNT_WIDTH'(DIV_CYCLES - 1));

endmodule

`default_nettype wire

// ----- design/rnrs_datapath.sv -----
// datapath: registers, generator, history ram, compares and response register
`default_nettype none

module rnrs_datapath import rnrs_pkg::*; #(
   parameter int NUM_SLOTS   = DEFAULT_NUM_SLOTS,
   parameter int MAX_HISTORY = DEFAULT_MAX_HISTORY
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic [SLOT_WIDTH-1:0]      req_slot,
   input  wire logic [COUNT_WIDTH-1:0]     req_choice_count,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [CHOICE_WIDTH-1:0]    rsp_choice,
   output logic      [DRAWS_WIDTH-1:0]     rsp_draws_used,
   output logic                            rsp_used_fallback
);

   localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CUR_W     = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int FILL_W    = $clog2(MAX_HISTORY + 1);
   localparam int HIST_W    = MAX_HISTORY * CHOICE_WIDTH;
   localparam int ROW_W     = HIST_W + CUR_W + FILL_W;
   localparam int SLOT_SPAN = 1 << SLOT_WIDTH;

   // configuration registers
   logic [HIST_REG_WIDTH-1:0] hist_len_ff, hist_len_in;
   logic [GEN_WIDTH-1:0]      seed_ff, seed_in;

   // request state
   logic                      seeded_ff, seeded_in;
   logic [GEN_WIDTH-1:0]      gen_ff, gen_in;
   logic [SLOT_AW-1:0]        slot_ff, slot_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [FILL_W-1:0]         limit_ff, limit_in;
   logic [DRAWS_WIDTH-1:0]    draws_ff, draws_in;
   logic [CHOICE_WIDTH-1:0]   choice_ff, choice_in;
   logic                      fallback_ff, fallback_in;
   logic [COUNT_WIDTH-1:0]    scan_ff, scan_in;
   logic [SLOT_AW-1:0]        clear_ff, clear_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHOICE_WIDTH-1:0]   rsp_choice_ff, rsp_choice_in;
   logic [DRAWS_WIDTH-1:0]    rsp_draws_ff, rsp_draws_in;
   logic                      rsp_fallback_ff, rsp_fallback_in;

   logic [SLOT_AW-1:0]        fold_tab [SLOT_SPAN];
   logic [SLOT_AW-1:0]        req_slot_idx;
   logic [GEN_WIDTH-1:0]      gen_next;
   logic [HIST_REG_WIDTH-1:0] hist_clamped;
   logic [COUNT_WIDTH-1:0]    limit_calc;

   logic                      ram_wr_en;
   logic [SLOT_AW-1:0]        ram_wr_addr;
   logic [ROW_W-1:0]          ram_wr_data;
   logic [ROW_W-1:0]          ram_rd_data;

   logic [FILL_W-1:0]         rd_fill;
   logic [CUR_W-1:0]          rd_cur;
   logic [CHOICE_WIDTH-1:0]   candidate;
   logic [CHOICE_WIDTH-1:0]   probe;
   logic                      probe_hit;

   logic [HIST_W-1:0]         new_hist;
   logic [CUR_W-1:0]          new_cur;
   logic [FILL_W:0]           fill_plus;
   logic [FILL_W-1:0]         new_fill;

   logic                      div_start;
   logic [GEN_WIDTH-1:0]      div_dividend;
   logic [COUNT_WIDTH-1:0]    div_divisor;
   logic [COUNT_WIDTH-1:0]    div_rem;
   logic                      div_last;

   // slot folded into the slot count, as a constant table
   for (genvar j = 0; j < SLOT_SPAN; j++) begin : g_fold
      assign fold_tab[j] = SLOT_AW'(j % NUM_SLOTS);
   end

   assign req_slot_idx = fold_tab[req_slot];
   assign gen_next     = xorshift32(gen_ff);

   // history limit: clamp length, then at most n-1 and the row size
   always_comb begin
      hist_clamped = hist_len_ff;
      if (hist_clamped == '0) begin
         hist_clamped = HIST_REG_WIDTH'(1);
      end
      if (hist_clamped > HISTORY_CAP) begin
         hist_clamped = HISTORY_CAP;
      end
      limit_calc = COUNT_WIDTH'(hist_clamped);
      if (req_choice_count == '0) begin
         limit_calc = '0;
      end else if (req_choice_count - 1'b1 < limit_calc) begin
         limit_calc = req_choice_count - 1'b1;
      end
      if (limit_calc > COUNT_WIDTH'(MAX_HISTORY)) begin
         limit_calc = COUNT_WIDTH'(MAX_HISTORY);
      end
   end

   // history row fields
   assign rd_fill   = ram_rd_data[ROW_W-1 -: FILL_W];
   assign rd_cur    = ram_rd_data[HIST_W +: CUR_W];
   assign candidate = (count_ff == '0) ? '0 : div_rem;
   assign probe     = cmd.use_scan ? scan_ff : candidate;

   always_comb begin
      probe_hit = 1'b0;
      for (int i = 0; i < MAX_HISTORY; i++) begin
         if ((FILL_W'(i) < rd_fill) &&
             (ram_rd_data[i*CHOICE_WIDTH +: CHOICE_WIDTH] == probe)) begin
            probe_hit = 1'b1;
         end
      end
   end

   // updated row: choice at the cursor, wrapped cursor, saturating fill
   always_comb begin
      new_hist = ram_rd_data[HIST_W-1:0];
      for (int i = 0; i < MAX_HISTORY; i++) begin
         if (CUR_W'(i) == rd_cur) begin
            new_hist[i*CHOICE_WIDTH +: CHOICE_WIDTH] = choice_ff;
         end
      end
      new_cur   = CUR_W'(div_rem);
      fill_plus = {1'b0, rd_fill} + 1'b1;
      new_fill  = (fill_plus < {1'b0, limit_ff}) ? fill_plus[FILL_W-1:0] : limit_ff;
   end

   // shared remainder unit: draw modulo n, cursor modulo limit
   assign div_start    = cmd.draw | cmd.wrap_start;
   assign div_dividend = cmd.draw ? gen_next
                                  : GEN_WIDTH'({1'b0, rd_cur} + 1'b1);
   assign div_divisor  = cmd.draw ? count_ff : COUNT_WIDTH'(limit_ff);

   rnrs_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .step      (cmd.div_step),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .remainder (div_rem),
      .last      (div_last)
   );

   assign ram_wr_en   = cmd.clear_step | (cmd.finish & (limit_ff != '0));
   assign ram_wr_addr = cmd.clear_step ? clear_ff : slot_ff;
   assign ram_wr_data = cmd.clear_step ? '0 : {new_fill, new_cur, new_hist};

   rnrs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SLOTS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.take_req),
      .rd_addr (req_slot_idx),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      hist_len_in     = hist_len_ff;
      seed_in         = seed_ff;
      seeded_in       = seeded_ff;
      gen_in          = gen_ff;
      slot_in         = slot_ff;
      count_in        = count_ff;
      limit_in        = limit_ff;
      draws_in        = draws_ff;
      choice_in       = choice_ff;
      fallback_in     = fallback_ff;
      scan_in         = scan_ff;
      clear_in        = clear_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_choice_in   = rsp_choice_ff;
      rsp_draws_in    = rsp_draws_ff;
      rsp_fallback_in = rsp_fallback_ff;

      if (csr_we) begin
         if (csr_index == CSR_HISTORY_LENGTH) begin
            hist_len_in = csr_wdata[HIST_REG_WIDTH-1:0];
         end
         if (csr_index == CSR_SEED) begin
            seed_in = csr_wdata[GEN_WIDTH-1:0];
         end
      end

      if (cmd.clear_step) begin
         clear_in = clear_ff + 1'b1;
      end

      if (cmd.take_req) begin
         slot_in  = req_slot_idx;
         count_in = req_choice_count;
         limit_in = FILL_W'(limit_calc);
         draws_in = '0;
         if (!seeded_ff) begin
            gen_in    = (seed_ff == '0) ? SEED_ZERO_SUBST : seed_ff;
            seeded_in = 1'b1;
         end
      end

      if (cmd.draw) begin
         gen_in   = gen_next;
         draws_in = draws_ff + 1'b1;
      end

      if (cmd.check) begin
         choice_in   = candidate;
         fallback_in = 1'b0;
         scan_in     = '0;
      end

      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
      end

      if (cmd.scan_take) begin
         choice_in   = scan_ff;
         fallback_in = 1'b1;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_choice_in   = choice_ff;
         rsp_draws_in    = draws_ff;
         rsp_fallback_in = fallback_ff;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff          <= gen_in;
      slot_ff         <= slot_in;
      count_ff        <= count_in;
      limit_ff        <= limit_in;
      draws_ff        <= draws_in;
      choice_ff       <= choice_in;
      fallback_ff     <= fallback_in;
      scan_ff         <= scan_in;
      rsp_choice_ff   <= rsp_choice_in;
      rsp_draws_ff    <= rsp_draws_in;
      rsp_fallback_ff <= rsp_fallback_in;
      if (reset) begin
         hist_len_ff  <= RESET_HISTORY_LENGTH;
         seed_ff      <= RESET_SEED;
         seeded_ff    <= 1'b0;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_len_ff  <= hist_len_in;
         seed_ff      <= seed_in;
         seeded_ff    <= seeded_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.clear_last   = (clear_ff == SLOT_AW'(NUM_SLOTS - 1));
      status.div_last     = div_last;
      status.probe_recent = probe_hit;
      status.redraw_ok    = (draws_ff <= {count_ff, 1'b0});
      status.scan_end     = (scan_ff == count_ff);
      status.limit_zero   = (limit_ff == '0);
      status.rsp_free     = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_choice        = rsp_choice_ff;
   assign rsp_draws_used    = rsp_draws_ff;
   assign rsp_used_fallback = rsp_fallback_ff;

endmodule

`default_nettype wire

// ----- design/rnrs_ctrl.sv -----
// controller state machine: sequences clear, draws, history checks and update
`default_nettype none

module rnrs_ctrl import rnrs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_DRAW;
            end
         end
         ST_DRAW: begin
            cmd.draw = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.probe_recent && status.redraw_ok) begin
               state_in = ST_DRAW;
            end else if (status.probe_recent) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_SCAN: begin
            cmd.use_scan = 1'b1;
            if (status.scan_end) begin
               state_in = ST_UPDATE;
            end else if (!status.probe_recent) begin
               cmd.scan_take = 1'b1;
               state_in      = ST_UPDATE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_UPDATE: begin
            if (status.limit_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.wrap_start = 1'b1;
               state_in       = ST_WRAP;
            end
         end
         ST_WRAP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/random_no_repeat_selector.sv -----
// top level of the random no-repeat selector
`default_nettype none

// random choice without recent repeat. each request names a history slot and a
// choice count n; the block answers with an index below n drawn from a shared
// xorshift32 generator (loaded from the seed register on the first request after
// reset, a zero seed replaced by 0x9e3779b9), redrawing up to 2n times while the
// draw sits in the slot's ring of recent choices and then falling back to the
// lowest index not in the ring. the ring keeps min(history_length, n-1,
// MAX_HISTORY) entries. after reset the block sweeps every row of the history
// ram before it takes the first request (csr writes are taken all along). one
// request is handled at a time: every generator draw steps through the generator
// advance, the radix-16 remainder unit and the history compare, a failed redraw
// run then probes the fallback indices in turn, and the history update runs the
// cursor wrap through the same remainder unit when the ring is in use. the
// response sits in an output register, so a finished request waits there while
// the next one runs

module random_no_repeat_selector import rnrs_pkg::*; #(
   parameter int NUM_SLOTS   = DEFAULT_NUM_SLOTS,
   parameter int MAX_HISTORY = DEFAULT_MAX_HISTORY
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   rnrs_req_if.sink                        req_chan,
   rnrs_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   rnrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // request accepted only while the controller sits idle
   assign req_chan.ready = req_ready;

   rnrs_datapath #(
      .NUM_SLOTS   (NUM_SLOTS),
      .MAX_HISTORY (MAX_HISTORY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_slot          (req_chan.slot),
      .req_choice_count  (req_chan.choice_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_choice        (rsp_chan.choice),
      .rsp_draws_used    (rsp_chan.draws_used),
      .rsp_used_fallback (rsp_chan.used_fallback)
   );

endmodule

`default_nettype wire
